[src/sed_pkg.sv]
// shared types and constants for the sprite entry to tile draw block
package sed_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_FLIP_SCREEN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TABLE = 1'd1;

    localparam logic [1:0] CLS_SINGLE = 2'd0;
    localparam logic [1:0] CLS_DOUBLE = 2'd1;
    localparam logic [1:0] CLS_QUAD   = 2'd2;
    localparam logic [1:0] CLS_FOUR   = 2'd3;

    localparam logic [9:0] SX_BIAS     = 10'd128;
    localparam logic [9:0] SY_BIAS     = 10'd369;
    localparam logic [9:0] SY_DOUBLE   = 10'd16;
    localparam logic [9:0] SY_QUAD     = 10'd48;
    localparam logic [9:0] FLIP_X_BASE = 10'd240;
    localparam logic [9:0] FLIP_Y_BASE = 10'd242;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [9:0] code;
        logic [1:0] last_row;
        logic [4:0] color;
        logic       fx;
        logic       fy;
        logic [9:0] sx;
        logic [9:0] sy;
    } desc_t;

endpackage

[src/sprite_entry_to_tile_draws.sv]
// top level: sprite entry in, tile draw commands out
//
//  channel  dir  handshake          payload
//  cfg      in   cfg_we             cfg_index, cfg_wdata
//  s_       in   s_valid/s_ready    sprite entry fields
//  m_       out  m_valid/m_ready    one tile draw command
//
// an entry yields 1, 2 or 4 tile commands, one per row, issued by the row
// sequencer in the back end; an empty slot is accepted but never queued
// the front accepts an entry per cycle while the two-entry queue has room
// a stalled result holds in the output register while the front keeps filling
// reset clears config, queue and sequencer state; no clearing pass
module sprite_entry_to_tile_draws (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [4:0]                      s_color,
    input  logic [7:0]                      s_y_low,
    input  logic                            s_y_high,
    input  logic [7:0]                      s_code_low,
    input  logic [1:0]                      s_code_high,
    input  logic                            s_mirror_x,
    input  logic                            s_mirror_y,
    input  logic [7:0]                      s_x_low,
    input  logic                            s_x_high,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [9:0]                      m_tile_code,
    output logic [4:0]                      m_tile_color,
    output logic                            m_draw_flip_x,
    output logic                            m_draw_flip_y,
    output logic signed [9:0]               m_pos_x,
    output logic signed [9:0]               m_pos_y,
    output logic                            m_last_tile
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    sed_pkg::desc_t q_in;
    sed_pkg::desc_t q_out;

    sed_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_color     (s_color),
        .s_y_low     (s_y_low),
        .s_y_high    (s_y_high),
        .s_code_low  (s_code_low),
        .s_code_high (s_code_high),
        .s_mirror_x  (s_mirror_x),
        .s_mirror_y  (s_mirror_y),
        .s_x_low     (s_x_low),
        .s_x_high    (s_x_high),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    sed_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    sed_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tile_code   (m_tile_code),
        .m_tile_color  (m_tile_color),
        .m_draw_flip_x (m_draw_flip_x),
        .m_draw_flip_y (m_draw_flip_y),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_last_tile   (m_last_tile)
    );

endmodule

[src/sed_front.sv]
// front end: config registers, empty slot filter and sprite classification
module sed_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [4:0]                      s_color,
    input  logic [7:0]                      s_y_low,
    input  logic                            s_y_high,
    input  logic [7:0]                      s_code_low,
    input  logic [1:0]                      s_code_high,
    input  logic                            s_mirror_x,
    input  logic                            s_mirror_y,
    input  logic [7:0]                      s_x_low,
    input  logic                            s_x_high,
    input  logic                            q_full,
    output logic                            q_push,
    output sed_pkg::desc_t                  q_data
);

    logic        flip_screen_reg;
    logic        flip_screen_next;
    logic [63:0] height_table_reg;
    logic [63:0] height_table_next;

    logic [9:0] code;
    logic [9:0] code_adj;
    logic [1:0] cls;
    logic [1:0] last_row;
    logic [9:0] sx0;
    logic [9:0] sy0;
    logic [9:0] sy1;

    always_comb begin
        flip_screen_next  = flip_screen_reg;
        height_table_next = height_table_reg;
        if (cfg_we) begin
            case (cfg_index)
                sed_pkg::REG_FLIP_SCREEN:  flip_screen_next  = cfg_wdata[0];
                sed_pkg::REG_HEIGHT_TABLE: height_table_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_screen_reg  <= 1'b0;
            height_table_reg <= 64'd0;
        end else begin
            flip_screen_reg  <= flip_screen_next;
            height_table_reg <= height_table_next;
        end
    end

    always_comb begin
        code = {s_code_high, s_code_low};
        cls  = height_table_reg[{code[9:5], 1'b0} +: 2];
        sx0  = {1'b0, s_x_high, s_x_low} - sed_pkg::SX_BIAS;
        sy0  = sed_pkg::SY_BIAS - {1'b0, s_y_high, s_y_low};
        case (cls)
            sed_pkg::CLS_DOUBLE: begin
                code_adj = {code[9:1], 1'b0};
                sy1      = sy0 - sed_pkg::SY_DOUBLE;
                last_row = 2'd1;
            end
            sed_pkg::CLS_QUAD: begin
                code_adj = {code[9:2], 2'b00};
                sy1      = sy0 - sed_pkg::SY_QUAD;
                last_row = 2'd3;
            end
            sed_pkg::CLS_FOUR: begin
                code_adj = code;
                sy1      = sy0;
                last_row = 2'd3;
            end
            default: begin
                code_adj = code;
                sy1      = sy0;
                last_row = 2'd0;
            end
        endcase

        q_data.code     = code_adj;
        q_data.last_row = last_row;
        q_data.color    = s_color;
        if (flip_screen_reg) begin
            q_data.sx = sed_pkg::FLIP_X_BASE - sx0;
            q_data.sy = sed_pkg::FLIP_Y_BASE - {4'd0, last_row, 4'd0} - sy1;
            q_data.fx = ~s_mirror_x;
            q_data.fy = ~s_mirror_y;
        end else begin
            q_data.sx = sx0;
            q_data.sy = sy1;
            q_data.fx = s_mirror_x;
            q_data.fy = s_mirror_y;
        end
    end

    // empty slots are dropped here and never reach the queue
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && (code != 10'd0);

endmodule

[src/sed_queue.sv]
// two-entry descriptor queue between front and back
module sed_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sed_pkg::desc_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sed_pkg::desc_t pop_data
);

    localparam int PTR_W = $clog2(sed_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sed_pkg::QUEUE_DEPTH + 1);

    sed_pkg::desc_t    mem_reg [sed_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(sed_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sed_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sed_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(sed_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

[src/sed_back.sv]
// back end: walks the rows of one sprite and drives the tile command register
module sed_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  sed_pkg::desc_t     q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_tile_code,
    output logic [4:0]         m_tile_color,
    output logic               m_draw_flip_x,
    output logic               m_draw_flip_y,
    output logic signed [9:0]  m_pos_x,
    output logic signed [9:0]  m_pos_y,
    output logic               m_last_tile
);

    sed_pkg::desc_t cur_reg;
    logic           cur_valid_reg;
    logic           cur_valid_next;
    logic [1:0]     row_reg;
    logic [1:0]     row_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [9:0]     tile_code_reg;
    logic [4:0]     tile_color_reg;
    logic           flip_x_reg;
    logic           flip_y_reg;
    logic [9:0]     pos_x_reg;
    logic [9:0]     pos_y_reg;
    logic           last_reg;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic [9:0] row_code;
    logic [9:0] row_y;

    assign out_free = !out_valid_reg || m_ready;
    assign emit     = cur_valid_reg && out_free;
    assign is_last  = (row_reg == cur_reg.last_row);
    assign q_pop    = q_not_empty && (!cur_valid_reg || (emit && is_last));

    // reverse code order under vertical flip
    assign row_code = cur_reg.fy ? cur_reg.code + {8'd0, cur_reg.last_row} - {8'd0, row_reg}
                                 : cur_reg.code + {8'd0, row_reg};
    assign row_y    = cur_reg.sy + {4'd0, row_reg, 4'd0};

    always_comb begin
        cur_valid_next = cur_valid_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            row_next       = row_reg + 1'b1;
            if (is_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_pop) begin
            cur_valid_next = 1'b1;
            row_next       = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            row_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (emit) begin
            tile_code_reg  <= row_code;
            tile_color_reg <= cur_reg.color;
            flip_x_reg     <= cur_reg.fx;
            flip_y_reg     <= cur_reg.fy;
            pos_x_reg      <= cur_reg.sx;
            pos_y_reg      <= row_y;
            last_reg       <= is_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_tile_code   = tile_code_reg;
    assign m_tile_color  = tile_color_reg;
    assign m_draw_flip_x = flip_x_reg;
    assign m_draw_flip_y = flip_y_reg;
    assign m_pos_x       = pos_x_reg;
    assign m_pos_y       = pos_y_reg;
    assign m_last_tile   = last_reg;

`ifndef NO_ASSERTIONS
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (row_reg <= cur_reg.last_row))
        else $error("row counter past last row");
    a_mid_sprite: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !is_last) |=> cur_valid_reg)
        else $error("sprite dropped before its last row");
    a_last_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !last_reg) |-> cur_valid_reg)
        else $error("non-final tile shown with no sprite in progress");
`endif

endmodule
